>>> hdl/sc1a_pkg.sv
`default_nettype none

package sc1a_pkg;

    // Special scan codes, set 1
    localparam logic [7:0] SC_PREFIX      = 8'hE0;
    localparam logic [7:0] SC_LSHIFT_MAKE = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BRK  = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BRK  = 8'hB6;
    localparam logic [7:0] SC_CAPS_MAKE   = 8'h3A;
    localparam logic [7:0] SC_EXT_UP      = 8'h48;
    localparam logic [7:0] SC_EXT_DOWN    = 8'h50;

    localparam int unsigned CHAR_W = 7;

    typedef struct packed {
        logic shift_held;
        logic caps_active;
        logic extended_pending;
    } t_flags;

    typedef struct packed {
        logic              char_valid;
        logic [CHAR_W-1:0] char_code;
        logic              history_up;
        logic              history_down;
    } t_result;

    // US layout, no modifier
    function automatic logic [CHAR_W-1:0] plain_char(input logic [6:0] idx);
        logic [CHAR_W-1:0] c;
        case (idx)
            7'd1:  c = 7'h1B;
            7'd2:  c = 7'h31;
            7'd3:  c = 7'h32;
            7'd4:  c = 7'h33;
            7'd5:  c = 7'h34;
            7'd6:  c = 7'h35;
            7'd7:  c = 7'h36;
            7'd8:  c = 7'h37;
            7'd9:  c = 7'h38;
            7'd10: c = 7'h39;
            7'd11: c = 7'h30;
            7'd12: c = 7'h2D;
            7'd13: c = 7'h3D;
            7'd14: c = 7'h08;
            7'd15: c = 7'h09;
            7'd16: c = 7'h71;
            7'd17: c = 7'h77;
            7'd18: c = 7'h65;
            7'd19: c = 7'h72;
            7'd20: c = 7'h74;
            7'd21: c = 7'h79;
            7'd22: c = 7'h75;
            7'd23: c = 7'h69;
            7'd24: c = 7'h6F;
            7'd25: c = 7'h70;
            7'd26: c = 7'h5B;
            7'd27: c = 7'h5D;
            7'd28: c = 7'h0A;
            7'd30: c = 7'h61;
            7'd31: c = 7'h73;
            7'd32: c = 7'h64;
            7'd33: c = 7'h66;
            7'd34: c = 7'h67;
            7'd35: c = 7'h68;
            7'd36: c = 7'h6A;
            7'd37: c = 7'h6B;
            7'd38: c = 7'h6C;
            7'd39: c = 7'h3B;
            7'd40: c = 7'h27;
            7'd41: c = 7'h60;
            7'd43: c = 7'h5C;
            7'd44: c = 7'h7A;
            7'd45: c = 7'h78;
            7'd46: c = 7'h63;
            7'd47: c = 7'h76;
            7'd48: c = 7'h62;
            7'd49: c = 7'h6E;
            7'd50: c = 7'h6D;
            7'd51: c = 7'h2C;
            7'd52: c = 7'h2E;
            7'd53: c = 7'h2F;
            7'd55: c = 7'h2A;
            7'd57: c = 7'h20;
            7'd74: c = 7'h2D;
            7'd78: c = 7'h2B;
            default: c = '0;
        endcase
        return c;
    endfunction

    // US layout, shift applied
    function automatic logic [CHAR_W-1:0] shifted_char(input logic [6:0] idx);
        logic [CHAR_W-1:0] c;
        case (idx)
            7'd1:  c = 7'h1B;
            7'd2:  c = 7'h21;
            7'd3:  c = 7'h40;
            7'd4:  c = 7'h23;
            7'd5:  c = 7'h24;
            7'd6:  c = 7'h25;
            7'd7:  c = 7'h5E;
            7'd8:  c = 7'h26;
            7'd9:  c = 7'h2A;
            7'd10: c = 7'h28;
            7'd11: c = 7'h29;
            7'd12: c = 7'h5F;
            7'd13: c = 7'h2B;
            7'd14: c = 7'h08;
            7'd15: c = 7'h09;
            7'd16: c = 7'h51;
            7'd17: c = 7'h57;
            7'd18: c = 7'h45;
            7'd19: c = 7'h52;
            7'd20: c = 7'h54;
            7'd21: c = 7'h59;
            7'd22: c = 7'h55;
            7'd23: c = 7'h49;
            7'd24: c = 7'h4F;
            7'd25: c = 7'h50;
            7'd26: c = 7'h7B;
            7'd27: c = 7'h7D;
            7'd28: c = 7'h0A;
            7'd30: c = 7'h41;
            7'd31: c = 7'h53;
            7'd32: c = 7'h44;
            7'd33: c = 7'h46;
            7'd34: c = 7'h47;
            7'd35: c = 7'h48;
            7'd36: c = 7'h4A;
            7'd37: c = 7'h4B;
            7'd38: c = 7'h4C;
            7'd39: c = 7'h3A;
            7'd40: c = 7'h22;
            7'd41: c = 7'h7E;
            7'd43: c = 7'h7C;
            7'd44: c = 7'h5A;
            7'd45: c = 7'h58;
            7'd46: c = 7'h43;
            7'd47: c = 7'h56;
            7'd48: c = 7'h42;
            7'd49: c = 7'h4E;
            7'd50: c = 7'h4D;
            7'd51: c = 7'h3C;
            7'd52: c = 7'h3E;
            7'd53: c = 7'h3F;
            7'd55: c = 7'h2A;
            7'd57: c = 7'h20;
            7'd74: c = 7'h2D;
            7'd78: c = 7'h2B;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hdl/sc1a_decode.sv
`default_nettype none

module sc1a_decode (
    input  wire logic [7:0]       i_scan_byte,
    input  wire logic             i_user_mode_active,
    input  wire sc1a_pkg::t_flags i_flags,
    output sc1a_pkg::t_flags      o_flags,
    output sc1a_pkg::t_result     o_result
);

    logic [sc1a_pkg::CHAR_W-1:0] w_plain;
    logic [sc1a_pkg::CHAR_W-1:0] w_shifted;
    logic                        w_letter;
    logic                        w_use_shift;
    logic [sc1a_pkg::CHAR_W-1:0] w_char;

    assign w_plain     = sc1a_pkg::plain_char(i_scan_byte[6:0]);
    assign w_shifted   = sc1a_pkg::shifted_char(i_scan_byte[6:0]);
    // letters in the plain table are lower case only
    assign w_letter    = (w_plain >= 7'h61) && (w_plain <= 7'h7A);
    assign w_use_shift = w_letter ? (i_flags.shift_held ^ i_flags.caps_active)
                                  : i_flags.shift_held;
    assign w_char      = w_use_shift ? w_shifted : w_plain;

    always_comb begin
        o_flags  = i_flags;
        o_result = '0;
        if (i_scan_byte == sc1a_pkg::SC_PREFIX) begin
            o_flags.extended_pending = 1'b1;
        end else if (i_flags.extended_pending) begin
            o_flags.extended_pending = 1'b0;
            o_result.history_up   = !i_user_mode_active &&
                                    (i_scan_byte == sc1a_pkg::SC_EXT_UP);
            o_result.history_down = !i_user_mode_active &&
                                    (i_scan_byte == sc1a_pkg::SC_EXT_DOWN);
        end else if (i_scan_byte inside {sc1a_pkg::SC_LSHIFT_MAKE,
                                         sc1a_pkg::SC_RSHIFT_MAKE}) begin
            o_flags.shift_held = 1'b1;
        end else if (i_scan_byte inside {sc1a_pkg::SC_LSHIFT_BRK,
                                         sc1a_pkg::SC_RSHIFT_BRK}) begin
            o_flags.shift_held = 1'b0;
        end else if (i_scan_byte == sc1a_pkg::SC_CAPS_MAKE) begin
            o_flags.caps_active = !i_flags.caps_active;
        end else if (!i_scan_byte[7] && (w_char != '0)) begin
            o_result.char_valid = 1'b1;
            o_result.char_code  = w_char;
        end
    end

endmodule

`default_nettype wire

>>> hdl/scan_code_set1_to_ascii_core.sv
`default_nettype none

// Set 1 scan code to ASCII decoder, US layout. Each accepted scan byte gives
// exactly one result word, in order: either a character (o_char_valid high
// with o_char_code), a history pulse for the extended up or down arrow while
// user mode is inactive, or an all-zero word. Shift, caps lock and the 0xE0
// prefix are tracked internally and update at the accept edge. One word is
// taken every cycle while the sink keeps ready high: the decode is a single
// table lookup that sits between the input handshake and one output register,
// so each result word is valid in the cycle after its scan byte is accepted.
module scan_code_set1_to_ascii_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [7:0]                  i_scan_byte,
    input  wire logic                        i_user_mode_active,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic                             o_char_valid,
    output logic [sc1a_pkg::CHAR_W-1:0]      o_char_code,
    output logic                             o_history_up,
    output logic                             o_history_down
);

    sc1a_pkg::t_flags  r_flags;
    sc1a_pkg::t_flags  n_flags;
    sc1a_pkg::t_result r_result;
    sc1a_pkg::t_result n_result;
    logic              r_valid;
    logic              w_accept;

    // Take a new word whenever the result register is empty or being drained.
    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    sc1a_decode u_decode (
        .i_scan_byte        (i_scan_byte),
        .i_user_mode_active (i_user_mode_active),
        .i_flags            (r_flags),
        .o_flags            (n_flags),
        .o_result           (n_result)
    );

    // Control state: keyboard flags and the result valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_flags <= n_flags;
            end
            // Advance on accept; drop valid once the sink has taken the word.
            if (w_accept) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Payload: hold while the sink stalls.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign o_valid        = r_valid;
    assign o_char_valid   = r_result.char_valid;
    assign o_char_code    = r_result.char_code;
    assign o_history_up   = r_result.history_up;
    assign o_history_down = r_result.history_down;

endmodule

`default_nettype wire

>>> dv/sc1a_checker.sv
`timescale 1ns / 1ps

module sc1a_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic                        i_in_ready,
    input  wire logic [7:0]                  i_scan_byte,
    input  wire logic                        i_user_mode_active,
    input  wire logic                        i_out_valid,
    input  wire logic                        i_out_ready,
    input  wire logic                        i_char_valid,
    input  wire logic [sc1a_pkg::CHAR_W-1:0] i_char_code,
    input  wire logic                        i_history_up,
    input  wire logic                        i_history_down,
    output int                               o_fail_count,
    output int                               o_words_pending
);

    localparam int         REPORT_LIMIT = 10;
    localparam int         BREAK_BIT    = 7;
    localparam logic [6:0] ASC_ESC      = 7'h1B;
    localparam logic [6:0] ASC_BS       = 7'h08;
    localparam logic [6:0] ASC_TAB      = 7'h09;
    localparam logic [6:0] ASC_LF       = 7'h0A;
    localparam logic [6:0] ASC_LOWER_A  = 7'h61;
    localparam logic [6:0] ASC_LOWER_Z  = 7'h7A;

    sc1a_pkg::t_flags  kbd_flags;
    sc1a_pkg::t_result expected_words[$];
    int                fail_total = 0;

    // US layout lookup by key index, plain or shifted
    function automatic logic [6:0] us_layout_char(input logic [6:0] idx, input logic shifted);
        string      num_row;
        string      top_row;
        string      home_row;
        string      low_row;
        logic [6:0] c;
        if (shifted) begin
            num_row  = "!@#$%^&*()_+";
            top_row  = "QWERTYUIOP{}";
            home_row = "ASDFGHJKL:\"";
            low_row  = "|ZXCVBNM<>?";
        end else begin
            num_row  = "1234567890-=";
            top_row  = "qwertyuiop[]";
            home_row = "asdfghjkl;'";
            low_row  = "\\zxcvbnm,./";
        end
        c = '0;
        if (idx >= 2 && idx <= 13) begin
            c = 7'(num_row[idx - 2]);
        end else if (idx >= 16 && idx <= 27) begin
            c = 7'(top_row[idx - 16]);
        end else if (idx >= 30 && idx <= 40) begin
            c = 7'(home_row[idx - 30]);
        end else if (idx >= 43 && idx <= 53) begin
            c = 7'(low_row[idx - 43]);
        end else begin
            case (idx)
                7'd1:    c = ASC_ESC;
                7'd14:   c = ASC_BS;
                7'd15:   c = ASC_TAB;
                7'd28:   c = ASC_LF;
                7'd41:   c = shifted ? 7'h7E : 7'h60;   // tilde over grave
                7'd55:   c = 7'h2A;                     // keypad star
                7'd57:   c = 7'h20;                     // space
                7'd74:   c = 7'h2D;                     // keypad minus
                7'd78:   c = 7'h2B;                     // keypad plus
                default: c = '0;
            endcase
        end
        return c;
    endfunction

    // Advance the keyboard flags by one scan byte and return the word it gives
    function automatic sc1a_pkg::t_result decode_scan(input logic [7:0] code,
                                                      input logic       user_mode);
        sc1a_pkg::t_result r;
        logic [6:0]        base;
        logic              use_shift;
        r = '0;
        if (code == sc1a_pkg::SC_PREFIX) begin
            kbd_flags.extended_pending = 1'b1;
        end else if (kbd_flags.extended_pending) begin
            kbd_flags.extended_pending = 1'b0;
            r.history_up   = !user_mode && code == sc1a_pkg::SC_EXT_UP;
            r.history_down = !user_mode && code == sc1a_pkg::SC_EXT_DOWN;
        end else if (code == sc1a_pkg::SC_LSHIFT_MAKE || code == sc1a_pkg::SC_RSHIFT_MAKE) begin
            kbd_flags.shift_held = 1'b1;
        end else if (code == sc1a_pkg::SC_LSHIFT_BRK || code == sc1a_pkg::SC_RSHIFT_BRK) begin
            kbd_flags.shift_held = 1'b0;
        end else if (code == sc1a_pkg::SC_CAPS_MAKE) begin
            kbd_flags.caps_active = !kbd_flags.caps_active;
        end else if (!code[BREAK_BIT]) begin
            base      = us_layout_char(code[6:0], 1'b0);
            use_shift = kbd_flags.shift_held;
            // caps lock only flips letters
            if (base >= ASC_LOWER_A && base <= ASC_LOWER_Z)
                use_shift = kbd_flags.shift_held ^ kbd_flags.caps_active;
            r.char_code  = use_shift ? us_layout_char(code[6:0], 1'b1) : base;
            r.char_valid = r.char_code != '0;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        sc1a_pkg::t_result got;
        sc1a_pkg::t_result want;
        if (!i_rst_n) begin
            kbd_flags = '0;
            expected_words.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                expected_words.push_back(decode_scan(i_scan_byte, i_user_mode_active));
            if (i_out_valid && i_out_ready) begin
                got = {i_char_valid, i_char_code, i_history_up, i_history_down};
                if (expected_words.size() == 0) begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT)
                        $display("%0t: unexpected word valid=%0b code=%02h up=%0b down=%0b",
                                 $realtime, got.char_valid, got.char_code,
                                 got.history_up, got.history_down);
                end else begin
                    want = expected_words.pop_front();
                    if (got.char_valid !== want.char_valid || got.char_code !== want.char_code
                        || got.history_up !== want.history_up
                        || got.history_down !== want.history_down) begin
                        fail_total++;
                        if (fail_total <= REPORT_LIMIT)
                            $display({"%0t: mismatch expected valid=%0b code=%02h up=%0b ",
                                      "down=%0b, got valid=%0b code=%02h up=%0b down=%0b"},
                                     $realtime, want.char_valid, want.char_code,
                                     want.history_up, want.history_down, got.char_valid,
                                     got.char_code, got.history_up, got.history_down);
                    end
                end
            end
        end
        o_fail_count    <= fail_total;
        o_words_pending <= expected_words.size();
    end

endmodule

>>> dv/tb_scan_code_set1_to_ascii_core.sv
`timescale 1ns / 1ps

module tb_scan_code_set1_to_ascii_core;

    localparam int RESET_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 4;
    localparam int WORDS_PER_PHASE = 170;

    // Key and break codes used by the directed and random parts
    localparam logic [7:0] KEY_A        = 8'h1E;
    localparam logic [7:0] KEY_1        = 8'h02;
    localparam logic [7:0] KEY_EQUAL    = 8'h0D;
    localparam logic [7:0] KEY_GRAVE    = 8'h29;
    localparam logic [7:0] KEY_PAD_PLUS = 8'h4E;
    localparam logic [7:0] KEY_NONE     = 8'h00;
    localparam logic [7:0] KEY_TOP      = 8'h7F;
    localparam logic [7:0] BREAK_BASE   = 8'h80;
    localparam logic [7:0] BREAK_TOP    = 8'hFF;

    logic                        i_clk              = 1'b0;
    logic                        i_rst_n            = 1'b0;
    logic                        i_valid            = 1'b0;
    logic                        o_ready;
    logic [7:0]                  i_scan_byte        = '0;
    logic                        i_user_mode_active = 1'b0;
    logic                        o_valid;
    logic                        i_ready            = 1'b0;
    logic                        o_char_valid;
    logic [sc1a_pkg::CHAR_W-1:0] o_char_code;
    logic                        o_history_up;
    logic                        o_history_down;

    int fail_count;
    int words_pending;
    int src_idle_pct   = 22;
    int sink_stall_pct = 81;
    int quiet_cycles   = 0;

    always #2 i_clk = ~i_clk;

    scan_code_set1_to_ascii_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_scan_byte        (i_scan_byte),
        .i_user_mode_active (i_user_mode_active),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_char_valid       (o_char_valid),
        .o_char_code        (o_char_code),
        .o_history_up       (o_history_up),
        .o_history_down     (o_history_down)
    );

    // Predicts each result word from the accepted scan bytes and scores it
    sc1a_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_valid),
        .i_in_ready         (o_ready),
        .i_scan_byte        (i_scan_byte),
        .i_user_mode_active (i_user_mode_active),
        .i_out_valid        (o_valid),
        .i_out_ready        (i_ready),
        .i_char_valid       (o_char_valid),
        .i_char_code        (o_char_code),
        .i_history_up       (o_history_up),
        .i_history_down     (o_history_down),
        .o_fail_count       (fail_count),
        .o_words_pending    (words_pending)
    );

    // Sink side: stall at random, one decision per falling edge
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Stop the run if the channels stay quiet for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one scan word. Enter and leave on a falling edge; hold valid and
    // payload steady until the word is taken.
    task automatic push_scan(input logic [7:0] code, input logic user_mode);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid            <= 1'b1;
        i_scan_byte        <= code;
        i_user_mode_active <= user_mode;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Mostly well-formed key activity with random content, plus some noise
    task automatic emit_random_sequence(output int words);
        int   pick;
        logic user_mode;
        pick      = $urandom_range(99);
        user_mode = 1'($urandom_range(1));
        words     = 1;
        if (pick < 45) begin
            push_scan(8'($urandom_range(127)), user_mode);
        end else if (pick < 60) begin
            push_scan(BREAK_BASE | 8'($urandom_range(127)), user_mode);
        end else if (pick < 70) begin
            case ($urandom_range(3))
                0:       push_scan(sc1a_pkg::SC_LSHIFT_MAKE, user_mode);
                1:       push_scan(sc1a_pkg::SC_RSHIFT_MAKE, user_mode);
                2:       push_scan(sc1a_pkg::SC_LSHIFT_BRK, user_mode);
                default: push_scan(sc1a_pkg::SC_RSHIFT_BRK, user_mode);
            endcase
        end else if (pick < 75) begin
            push_scan(sc1a_pkg::SC_CAPS_MAKE, user_mode);
        end else if (pick < 90) begin
            // extended pair: arrows most of the time, anything else otherwise
            push_scan(sc1a_pkg::SC_PREFIX, 1'($urandom_range(1)));
            words = 2;
            case ($urandom_range(4))
                0, 1:    push_scan(sc1a_pkg::SC_EXT_UP, user_mode);
                2, 3:    push_scan(sc1a_pkg::SC_EXT_DOWN, user_mode);
                default: push_scan(8'($urandom_range(255)), user_mode);
            endcase
        end else begin
            push_scan(8'($urandom_range(255)), user_mode);
        end
    endtask

    initial begin
        int sent;
        int burst;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: table edges, shift and caps interplay, prefix handling
        push_scan(KEY_NONE, 1'b0);                  // zero entry, all-zero word out
        push_scan(KEY_A, 1'b0);                     // plain letter
        push_scan(KEY_1, 1'b1);                     // plain digit, user mode has no effect
        push_scan(sc1a_pkg::SC_LSHIFT_MAKE, 1'b0);
        push_scan(KEY_A, 1'b0);                     // shifted letter
        push_scan(KEY_1, 1'b0);                     // shifted digit
        push_scan(sc1a_pkg::SC_LSHIFT_BRK, 1'b0);
        push_scan(sc1a_pkg::SC_CAPS_MAKE, 1'b0);
        push_scan(KEY_A, 1'b0);                     // caps lifts letters
        push_scan(KEY_1, 1'b0);                     // caps leaves digits alone
        push_scan(sc1a_pkg::SC_RSHIFT_MAKE, 1'b0);
        push_scan(KEY_A, 1'b0);                     // shift and caps cancel on letters
        push_scan(KEY_GRAVE, 1'b0);                 // shift still applies to symbols
        push_scan(sc1a_pkg::SC_PREFIX, 1'b0);
        push_scan(sc1a_pkg::SC_LSHIFT_BRK, 1'b0);   // swallowed by the prefix, shift stays
        push_scan(KEY_EQUAL, 1'b0);
        push_scan(sc1a_pkg::SC_RSHIFT_BRK, 1'b0);
        push_scan(sc1a_pkg::SC_CAPS_MAKE, 1'b1);    // caps back off
        push_scan(sc1a_pkg::SC_PREFIX, 1'b0);
        push_scan(sc1a_pkg::SC_EXT_UP, 1'b0);       // history up
        push_scan(sc1a_pkg::SC_PREFIX, 1'b0);
        push_scan(sc1a_pkg::SC_EXT_DOWN, 1'b1);     // suppressed in user mode
        push_scan(sc1a_pkg::SC_PREFIX, 1'b0);
        push_scan(sc1a_pkg::SC_PREFIX, 1'b1);       // repeated prefix keeps it armed
        push_scan(sc1a_pkg::SC_EXT_DOWN, 1'b0);     // history down
        push_scan(KEY_TOP, 1'b1);
        push_scan(BREAK_TOP, 1'b1);
        push_scan(KEY_PAD_PLUS, 1'b0);

        // Random: slow source and busy sink, then swapped, then full rate
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin src_idle_pct = 22; sink_stall_pct = 81; end
                1:       begin src_idle_pct = 81; sink_stall_pct = 22; end
                default: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            endcase
            sent = 0;
            while (sent < WORDS_PER_PHASE) begin
                emit_random_sequence(burst);
                sent += burst;
            end
        end

        // Drop valid and let the last results drain
        i_valid <= 1'b0;
        while (words_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && words_pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
hdl/sc1a_pkg.sv
hdl/sc1a_decode.sv
hdl/scan_code_set1_to_ascii_core.sv
dv/sc1a_checker.sv
dv/tb_scan_code_set1_to_ascii_core.sv
